// File: hw/rtl/ufs_pkg.sv
// Shared types, codes and character helpers for the URI field splitter.
package ufs_pkg;

   typedef enum logic [3:0] {
      MODE_LEAD,
      MODE_SLASH1,
      MODE_SLASH2,
      MODE_HOST_EMPTY,
      MODE_HOST_LABEL,
      MODE_PORT_START,
      MODE_PORT_DIGITS,
      MODE_SEG_START,
      MODE_SEG,
      MODE_SKIP
   } mode_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_REPLAY,
      CS_STEP,
      CS_PATH,
      CS_STATUS
   } ctrl_state_type;

   localparam logic [2:0] TAG_SCHEME = 3'd0;
   localparam logic [2:0] TAG_HOST   = 3'd1;
   localparam logic [2:0] TAG_PORT   = 3'd2;
   localparam logic [2:0] TAG_PATH   = 3'd3;
   localparam logic [2:0] TAG_STATUS = 3'd4;

   localparam logic [1:0] STS_OK     = 2'd0;
   localparam logic [1:0] STS_SYNTAX = 2'd1;
   localparam logic [1:0] STS_LONG   = 2'd2;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_DOT   = 8'h2E;

   typedef struct packed {
      logic accept;
      logic replay_emit;
      logic step_held;
      logic emit_path;
      logic emit_status;
   } ufs_cmd_type;

   typedef struct packed {
      logic out_free;
      logic needs_replay;
      logic req_end;
      logic held_end;
      logic replay_last;
      logic replay_scheme;
      logic need_path;
   } ufs_stat_type;

   function automatic logic is_letter(input logic [7:0] c);
      is_letter = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = (c >= 8'h30 && c <= 8'h39);
   endfunction

endpackage

// File: hw/rtl/ufs_req_if.sv
// Input channel: one URI byte per beat.
interface ufs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink (input valid, input char_in, output ready);
endinterface

// File: hw/rtl/ufs_rsp_if.sv
// Result channel: one tagged character or the closing status per beat.
interface ufs_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] field_tag;
   logic [7:0] char_out;
   logic [1:0] status;
   logic       is_last;

   modport source (output valid, output field_tag, output char_out, output status,
                   output is_last, input ready);
   modport sink (input valid, input field_tag, input char_out, input status,
                 input is_last, output ready);
endinterface

// File: hw/rtl/uri_field_splitter.sv
// Top level of the URI field splitter: takes one URI byte per beat, a zero byte
// ending the URI, and returns its field characters tagged as scheme, host, port
// or path, closing every URI with one status beat. An ordinary byte is taken
// whenever the result register is free. Leading letters are held in a MAX_WORD-1
// entry register buffer; the byte that ends them stalls the input while the buffer
// is replayed, one held letter after another, and, when the letters become the
// host, while that byte is processed. The zero byte is followed by a path state,
// which sends the default path slash when it is due, and a status state. Throughput
// is set by the single result register: at most one result beat leaves per cycle.
module uri_field_splitter
   import ufs_pkg::*;
#(
   parameter int MAX_WORD = 32
)
(
   input  logic       clock,
   input  logic       reset,
   ufs_req_if.sink    req_chan,
   ufs_rsp_if.source  rsp_chan
);

   ufs_cmd_type  cmd;
   ufs_stat_type stat;

   ufs_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ufs_datapath #(
      .MAX_WORD (MAX_WORD)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_char   (req_chan.char_in),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_tag    (rsp_chan.field_tag),
      .rsp_char   (rsp_chan.char_out),
      .rsp_status (rsp_chan.status),
      .rsp_last   (rsp_chan.is_last)
   );

endmodule

// File: hw/rtl/ufs_controller.sv
// Sequencer that steps through accept, lead-word replay, held step and end beats.
module ufs_controller
   import ufs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ufs_stat_type stat,
   output ufs_cmd_type  cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         CS_IDLE: begin
            req_ready = stat.out_free;
            if (req_valid && stat.out_free) begin
               cmd.accept = 1'b1;
               if (stat.needs_replay) begin
                  state_in = CS_REPLAY;
               end else if (stat.req_end) begin
                  state_in = CS_PATH;
               end
            end
         end
         CS_REPLAY: begin
            if (stat.out_free) begin
               cmd.replay_emit = 1'b1;
               if (stat.replay_last) begin
                  state_in = stat.replay_scheme ? CS_IDLE : CS_STEP;
               end
            end
         end
         CS_STEP: begin
            if (stat.out_free) begin
               cmd.step_held = 1'b1;
               state_in      = stat.held_end ? CS_PATH : CS_IDLE;
            end
         end
         CS_PATH: begin
            if (!stat.need_path) begin
               state_in = CS_STATUS;
            end else if (stat.out_free) begin
               cmd.emit_path = 1'b1;
               state_in      = CS_STATUS;
            end
         end
         CS_STATUS: begin
            if (stat.out_free) begin
               cmd.emit_status = 1'b1;
               state_in        = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

endmodule

// File: hw/rtl/ufs_datapath.sv
// Parse state, lead-word buffer, per-byte grammar step and result register.
module ufs_datapath
   import ufs_pkg::*;
#(
   parameter int MAX_WORD = 32
)
(
   input  logic         clock,
   input  logic         reset,
   input  ufs_cmd_type  cmd,
   output ufs_stat_type stat,
   input  logic [7:0]   req_char,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output logic [2:0]   rsp_tag,
   output logic [7:0]   rsp_char,
   output logic [1:0]   rsp_status,
   output logic         rsp_last
);

   localparam int CW        = $clog2(MAX_WORD);
   localparam int BUF_DEPTH = MAX_WORD - 1;
   localparam int IW        = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam logic [CW-1:0] WORD_LIMIT = CW'(MAX_WORD - 1);

   mode_type        mode_ff, mode_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   wlen_ff, wlen_in;
   logic [CW-1:0]   idx_ff, idx_in;
   logic            path_ff, path_in;
   logic [1:0]      err_ff, err_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      held_ff, held_in;
   logic            scheme_ff, scheme_in;
   logic [2:0]      tag_ff, tag_in;
   logic [7:0]      chr_ff, chr_in;
   logic [1:0]      sts_ff, sts_in;
   logic            last_ff, last_in;
   logic [7:0]      buf_ff [BUF_DEPTH];
   logic            buf_we;

   logic            out_free;
   logic            req_letter;
   logic            lead_letter;
   logic            lead_scheme;
   logic            lead_host;
   logic            needs_replay;
   logic            do_step;
   logic [7:0]      cur_c;
   logic            c_letter;
   logic            c_digit;
   logic            c_zero;
   mode_type        step_mode;
   logic            s_emit;
   logic [2:0]      s_tag;
   logic [7:0]      s_ch;
   mode_type        s_mode;
   logic [CW-1:0]   s_wlen;
   logic            s_path;
   logic            s_fail;
   logic [1:0]      s_code;

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign req_letter   = is_letter(req_char);
   assign lead_letter  = (mode_ff == MODE_LEAD) && req_letter;
   assign lead_scheme  = (mode_ff == MODE_LEAD) && (req_char == CH_COLON) && (count_ff != '0);
   assign lead_host    = (mode_ff == MODE_LEAD) && !req_letter && !lead_scheme;
   assign needs_replay = lead_scheme || (lead_host && (count_ff != '0));
   assign do_step      = (cmd.accept && !lead_letter && !needs_replay) || cmd.step_held;

   assign cur_c     = cmd.step_held ? held_ff : req_char;
   assign c_letter  = is_letter(cur_c);
   assign c_digit   = is_digit(cur_c);
   assign c_zero    = (cur_c == CH_NUL);
   assign step_mode = (!cmd.step_held && lead_host) ? MODE_HOST_EMPTY : mode_ff;

   always_comb begin
      stat.out_free      = out_free;
      stat.needs_replay  = needs_replay;
      stat.req_end       = (req_char == CH_NUL);
      stat.held_end      = (held_ff == CH_NUL);
      stat.replay_last   = (idx_ff == (count_ff - CW'(1)));
      stat.replay_scheme = scheme_ff;
      stat.need_path     = (err_ff == STS_OK) && !path_ff;
   end

   // grammar step for one byte
   always_comb begin
      s_emit = 1'b0;
      s_tag  = TAG_HOST;
      s_ch   = cur_c;
      s_mode = step_mode;
      s_wlen = wlen_ff;
      s_path = 1'b0;
      s_fail = 1'b0;
      s_code = STS_SYNTAX;
      case (step_mode)
         MODE_SLASH1: begin
            if (cur_c == CH_SLASH) begin
               s_mode = MODE_SLASH2;
            end else begin
               s_fail = 1'b1;
            end
         end
         MODE_SLASH2: begin
            if (cur_c == CH_SLASH) begin
               s_mode = MODE_HOST_EMPTY;
               s_wlen = '0;
            end else begin
               s_fail = 1'b1;
            end
         end
         MODE_HOST_EMPTY, MODE_HOST_LABEL: begin
            if (c_letter) begin
               if (wlen_ff >= WORD_LIMIT) begin
                  s_fail = 1'b1;
                  s_code = STS_LONG;
               end else begin
                  s_wlen = wlen_ff + CW'(1);
                  s_emit = 1'b1;
                  s_tag  = TAG_HOST;
                  s_mode = MODE_HOST_LABEL;
               end
            end else if (cur_c == CH_DOT && step_mode == MODE_HOST_LABEL) begin
               s_emit = 1'b1;
               s_tag  = TAG_HOST;
               s_wlen = '0;
               s_mode = MODE_HOST_EMPTY;
            end else if (cur_c == CH_COLON) begin
               s_wlen = '0;
               s_mode = MODE_PORT_START;
            end else if (cur_c == CH_SLASH) begin
               s_emit = 1'b1;
               s_tag  = TAG_PATH;
               s_path = 1'b1;
               s_wlen = '0;
               s_mode = MODE_SEG_START;
            end else if (!c_zero) begin
               s_fail = 1'b1;
            end
         end
         MODE_PORT_START, MODE_PORT_DIGITS: begin
            if (c_digit) begin
               if (wlen_ff >= WORD_LIMIT) begin
                  s_fail = 1'b1;
                  s_code = STS_LONG;
               end else begin
                  s_wlen = wlen_ff + CW'(1);
                  s_emit = 1'b1;
                  s_tag  = TAG_PORT;
                  s_mode = MODE_PORT_DIGITS;
               end
            end else if (step_mode == MODE_PORT_DIGITS && cur_c == CH_SLASH) begin
               s_emit = 1'b1;
               s_tag  = TAG_PATH;
               s_path = 1'b1;
               s_wlen = '0;
               s_mode = MODE_SEG_START;
            end else if (step_mode == MODE_PORT_START || !c_zero) begin
               s_fail = 1'b1;
            end
         end
         MODE_SEG_START, MODE_SEG: begin
            if (c_letter) begin
               if (wlen_ff >= WORD_LIMIT) begin
                  s_fail = 1'b1;
                  s_code = STS_LONG;
               end else begin
                  s_wlen = wlen_ff + CW'(1);
                  s_emit = 1'b1;
                  s_tag  = TAG_PATH;
                  s_mode = MODE_SEG;
               end
            end else if (cur_c == CH_SLASH && step_mode == MODE_SEG) begin
               s_emit = 1'b1;
               s_tag  = TAG_PATH;
               s_path = 1'b1;
               s_wlen = '0;
               s_mode = MODE_SEG_START;
            end else if (!c_zero) begin
               s_fail = 1'b1;
            end
         end
         default: begin
            s_mode = MODE_SKIP;
         end
      endcase
      if (s_fail) begin
         s_mode = MODE_SKIP;
      end
   end

   always_comb begin
      mode_in      = mode_ff;
      count_in     = count_ff;
      wlen_in      = wlen_ff;
      idx_in       = idx_ff;
      path_in      = path_ff;
      err_in       = err_ff;
      held_in      = held_ff;
      scheme_in    = scheme_ff;
      buf_we       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      tag_in       = tag_ff;
      chr_in       = chr_ff;
      sts_in       = sts_ff;
      last_in      = last_ff;

      if (cmd.accept) begin
         if (lead_letter) begin
            if (count_ff >= WORD_LIMIT) begin
               mode_in = MODE_SKIP;
               if (err_ff == STS_OK) begin
                  err_in = STS_LONG;
               end
            end else begin
               buf_we   = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end else if (needs_replay) begin
            held_in   = req_char;
            scheme_in = lead_scheme;
            idx_in    = '0;
         end
      end

      if (do_step) begin
         mode_in = s_mode;
         wlen_in = s_wlen;
         if (s_path) begin
            path_in = 1'b1;
         end
         if (s_fail && err_ff == STS_OK) begin
            err_in = s_code;
         end
         if (s_emit) begin
            rsp_valid_in = 1'b1;
            tag_in       = s_tag;
            chr_in       = s_ch;
            sts_in       = STS_OK;
            last_in      = 1'b0;
         end
      end

      if (cmd.replay_emit) begin
         rsp_valid_in = 1'b1;
         tag_in       = scheme_ff ? TAG_SCHEME : TAG_HOST;
         chr_in       = buf_ff[idx_ff[IW-1:0]];
         sts_in       = STS_OK;
         last_in      = 1'b0;
         idx_in       = idx_ff + CW'(1);
         if (stat.replay_last) begin
            if (scheme_ff) begin
               mode_in = MODE_SLASH1;
            end else begin
               mode_in = MODE_HOST_LABEL;
               wlen_in = count_ff;
            end
         end
      end

      if (cmd.emit_path) begin
         rsp_valid_in = 1'b1;
         tag_in       = TAG_PATH;
         chr_in       = CH_SLASH;
         sts_in       = STS_OK;
         last_in      = 1'b0;
      end

      if (cmd.emit_status) begin
         rsp_valid_in = 1'b1;
         tag_in       = TAG_STATUS;
         chr_in       = CH_NUL;
         sts_in       = err_ff;
         last_in      = 1'b1;
         mode_in      = MODE_LEAD;
         count_in     = '0;
         wlen_in      = '0;
         path_in      = 1'b0;
         err_in       = STS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_LEAD;
         count_ff     <= '0;
         wlen_ff      <= '0;
         idx_ff       <= '0;
         path_ff      <= 1'b0;
         err_ff       <= STS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         wlen_ff      <= wlen_in;
         idx_ff       <= idx_in;
         path_ff      <= path_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff   <= held_in;
      scheme_ff <= scheme_in;
      tag_ff    <= tag_in;
      chr_ff    <= chr_in;
      sts_ff    <= sts_in;
      last_ff   <= last_in;
      if (buf_we) begin
         buf_ff[count_ff[IW-1:0]] <= req_char;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_tag    = tag_ff;
   assign rsp_char   = chr_ff;
   assign rsp_status = sts_ff;
   assign rsp_last   = last_ff;

endmodule

// File: hw/rtl/ufs_checker.sv
// Port-level checks on the URI field splitter result channel, bound to the top level.
module ufs_checker
   import ufs_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] field_tag,
   input logic [1:0] status,
   input logic       is_last
);

   // hold a stalled beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (is_last == (field_tag == TAG_STATUS)))
      else $error("last flag and status tag disagree");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !is_last |-> status == STS_OK)
      else $error("status set on a character beat");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind uri_field_splitter ufs_checker u_ufs_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .field_tag (rsp_chan.field_tag),
   .status    (rsp_chan.status),
   .is_last   (rsp_chan.is_last)
);
